[rtl/core/smp_pkg.sv]
package smp_pkg;

   // bus access kinds
   typedef enum logic [1:0] {
      MODE_MEM_RD = 2'd0,
      MODE_MEM_WR = 2'd1,
      MODE_IO_IN  = 2'd2,
      MODE_IO_OUT = 2'd3
   } mode_type;

   // result targets
   localparam logic [2:0] TGT_INTERNAL = 3'd0;
   localparam logic [2:0] TGT_BIOS     = 3'd1;
   localparam logic [2:0] TGT_CART     = 3'd2;
   localparam logic [2:0] TGT_EXTIO    = 3'd3;
   localparam logic [2:0] TGT_NONE     = 3'd4;

   // io port numbers
   localparam logic [7:0] PORT_SLOT      = 8'hA8;
   localparam logic [7:0] PORT_KEYS      = 8'hA9;
   localparam logic [7:0] PORT_PPIC      = 8'hAA;
   localparam logic [7:0] PORT_BITSR     = 8'hAB;
   localparam logic [7:0] PORT_VDP_DATA  = 8'h98;
   localparam logic [7:0] PORT_VDP_CTRL  = 8'h99;
   localparam logic [7:0] PORT_PSG_ADDR  = 8'hA0;
   localparam logic [7:0] PORT_PSG_WRITE = 8'hA1;
   localparam logic [7:0] PORT_PSG_READ  = 8'hA2;

   // slot codes
   localparam logic [1:0] SLOT_BIOS = 2'd0;
   localparam logic [1:0] SLOT_RAM  = 2'd3;

   localparam logic [15:0] BIOS_MASK   = 16'h7FFF;
   localparam logic [3:0]  LAST_ROW    = 4'd8;
   localparam logic [7:0]  SLOT_RESET  = 8'hF0;
   localparam int          RAM_ADDR_W  = 16;

   // one accepted bus access
   typedef struct packed {
      mode_type    mode;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic [7:0]  key_pressed;
   } req_type;

   // decode result: response fields plus state and ram updates
   typedef struct packed {
      logic        ram_sel;
      logic [7:0]  reg_data;
      logic [2:0]  target;
      logic [15:0] target_address;
      logic        ram_we;
      logic        slot_we;
      logic [7:0]  slot_value;
      logic        portc_we;
      logic [7:0]  portc_value;
   } dec_type;

endpackage

[rtl/core/smp_decode.sv]
module smp_decode
   import smp_pkg::*;
(
   input  req_type    item,
   input  logic [7:0] slot_select,
   input  logic [7:0] port_c,
   output dec_type    dec
);

   logic [1:0] slot;
   logic [7:0] port;
   logic [7:0] bit_mask;

   // slot of the 16k page that the address falls in
   always_comb begin
      unique case (item.address[15:14])
         2'd0:    slot = slot_select[1:0];
         2'd1:    slot = slot_select[3:2];
         2'd2:    slot = slot_select[5:4];
         default: slot = slot_select[7:6];
      endcase
   end

   assign port     = item.address[7:0];
   assign bit_mask = 8'd1 << item.write_data[3:1];

   always_comb begin
      dec = '0;
      dec.target = TGT_NONE;
      unique case (item.mode)
         MODE_MEM_RD: begin
            if (slot == SLOT_BIOS) begin
               dec.target         = TGT_BIOS;
               dec.target_address = item.address & BIOS_MASK;
            end else if (slot == SLOT_RAM) begin
               dec.target  = TGT_INTERNAL;
               dec.ram_sel = 1'b1;
            end else begin
               dec.target         = TGT_CART;
               dec.target_address = item.address;
            end
         end
         MODE_MEM_WR: begin
            if (slot == SLOT_RAM) begin
               dec.target = TGT_INTERNAL;
               dec.ram_we = 1'b1;
            end
         end
         MODE_IO_IN: begin
            unique case (port)
               PORT_SLOT: begin
                  dec.target   = TGT_INTERNAL;
                  dec.reg_data = slot_select;
               end
               PORT_PPIC: begin
                  dec.target   = TGT_INTERNAL;
                  dec.reg_data = port_c;
               end
               PORT_KEYS: begin
                  dec.target   = TGT_INTERNAL;
                  dec.reg_data = (port_c[3:0] <= LAST_ROW) ? ~item.key_pressed : 8'hFF;
               end
               PORT_VDP_DATA, PORT_VDP_CTRL, PORT_PSG_READ: begin
                  dec.target         = TGT_EXTIO;
                  dec.target_address = {8'h00, port};
               end
               default: ;
            endcase
         end
         MODE_IO_OUT: begin
            unique case (port)
               PORT_SLOT: begin
                  dec.target     = TGT_INTERNAL;
                  dec.slot_we    = 1'b1;
                  dec.slot_value = item.write_data;
               end
               PORT_PPIC: begin
                  dec.target      = TGT_INTERNAL;
                  dec.portc_we    = 1'b1;
                  dec.portc_value = item.write_data;
               end
               PORT_BITSR: begin
                  dec.target      = TGT_INTERNAL;
                  dec.portc_we    = 1'b1;
                  dec.portc_value = item.write_data[0] ? (port_c | bit_mask)
                                                       : (port_c & ~bit_mask);
               end
               PORT_VDP_DATA, PORT_VDP_CTRL, PORT_PSG_ADDR, PORT_PSG_WRITE: begin
                  dec.target         = TGT_EXTIO;
                  dec.target_address = {8'h00, port};
               end
               default: ;
            endcase
         end
      endcase
   end

endmodule

[rtl/core/smp_ram.sv]
module smp_ram
   import smp_pkg::*;
(
   input  logic                  clock,
   input  logic                  en,
   input  logic                  we,
   input  logic [RAM_ADDR_W-1:0] addr,
   input  logic [7:0]            wdata,
   output logic [7:0]            rdata
);

   logic [7:0] mem [2**RAM_ADDR_W];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/slot_mapper_and_ppi_ports_top.sv]
// primary slot mapper and ppi ports of a small cpu bus
//
// req channel: one cpu bus access per transfer (mode, address, write data and
//   the key lines of the currently selected keyboard row)
// rsp channel: one result per request transfer, in order: read data, target,
//   target address and the keyboard row selected after the access
// path: a request transfer passes through the input register, then the result
//   register, which also holds the registered internal ram read
// throughput: one transfer per cycle while rsp_stall is low; set by the single
//   ram port, used once per access between the input and the result register
// a request is taken while a finished result still waits on rsp_stall; once
//   both registers are full, req_stall is raised until the result is taken
// reset: slot register = f0 (pages 0,1 in slot 0, pages 2,3 in slot 3), ppi
//   port c = 0, both pipeline stages emptied; the internal ram is not cleared
//   and a location reads back undefined until it has been written
module slot_mapper_and_ppi_ports_top
   import smp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   input  logic [7:0]  req_key_pressed,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic [2:0]  rsp_target,
   output logic [15:0] rsp_target_address,
   output logic [3:0]  rsp_key_row
);

   // input stage
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_item_ff;

   // architectural state
   logic [7:0] slot_ff, slot_in;
   logic [7:0] port_c_ff, port_c_in;

   // result stage
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_ram_sel_ff;
   logic [7:0]  rsp_reg_data_ff;
   logic [2:0]  rsp_target_ff;
   logic [15:0] rsp_target_address_ff;
   logic [3:0]  rsp_key_row_ff;

   logic    advance;
   logic    req_take;
   logic    step;
   dec_type dec;
   logic [7:0] ram_rdata;

   // result register is free or being drained this cycle
   assign advance  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   // the item in the input stage moves to the result stage
   assign step      = s1_valid_ff && advance;

   smp_decode u_decode (
      .item        (s1_item_ff),
      .slot_select (slot_ff),
      .port_c      (port_c_ff),
      .dec         (dec)
   );

   // ram read data lands together with the rest of the result
   smp_ram u_ram (
      .clock (clock),
      .en    (step),
      .we    (dec.ram_we),
      .addr  (s1_item_ff.address),
      .wdata (s1_item_ff.write_data),
      .rdata (ram_rdata)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
      slot_in   = (step && dec.slot_we)  ? dec.slot_value  : slot_ff;
      port_c_in = (step && dec.portc_we) ? dec.portc_value : port_c_ff;
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         slot_ff      <= SLOT_RESET;
         port_c_ff    <= 8'h00;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         slot_ff      <= slot_in;
         port_c_ff    <= port_c_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff.mode        <= mode_type'(req_mode);
         s1_item_ff.address     <= req_address;
         s1_item_ff.write_data  <= req_write_data;
         s1_item_ff.key_pressed <= req_key_pressed;
      end
      if (step) begin
         rsp_ram_sel_ff        <= dec.ram_sel;
         rsp_reg_data_ff       <= dec.reg_data;
         rsp_target_ff         <= dec.target;
         rsp_target_address_ff <= dec.target_address;
         // row selected after this access
         rsp_key_row_ff        <= port_c_in[3:0];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_data      = rsp_ram_sel_ff ? ram_rdata : rsp_reg_data_ff;
   assign rsp_target         = rsp_target_ff;
   assign rsp_target_address = rsp_target_address_ff;
   assign rsp_key_row        = rsp_key_row_ff;

   // the held result always reports the row that port c selects now
   a_key_row_tracks_port_c: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_key_row_ff == port_c_ff[3:0])
      else $error("key row out of step with port c");

   // only bios, cartridge and external io carry an address
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_target_ff == TGT_INTERNAL || rsp_target_ff == TGT_NONE)
      |-> rsp_target_address_ff == 16'h0000)
      else $error("address on a target that takes none");

   // bios sees a 15 bit address, external io a port number
   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_target_ff == TGT_BIOS || rsp_target_ff == TGT_EXTIO)
      |-> !rsp_target_address_ff[15] && !rsp_ram_sel_ff)
      else $error("bios or io address out of range");

   // nothing comes back from inside the block for outside targets
   a_no_data_outside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_target_ff == TGT_EXTIO || rsp_target_ff == TGT_NONE)
      |-> rsp_read_data == 8'h00)
      else $error("read data on an outside target");

   // stalling the requester means both stages are occupied
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff)
      else $error("request stalled with a free stage");

endmodule
